// File: src/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the protobuf field scanner.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // Largest message the scanner walks through; a byte beyond it is malformed.
    localparam int unsigned MAX_MESSAGE_BYTES = 65536;

    // Width of byte offsets and lengths, fixed by the result format.
    localparam int unsigned OFS_W = 17;

    localparam logic [OFS_W-1:0] MAX_MSG = OFS_W'(MAX_MESSAGE_BYTES);

    // A varint may use at most this many bytes.
    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    // Wire types that the scanner knows how to skip.
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        status_t          status;
        logic [2:0]       wire_kind;
        logic [OFS_W-1:0] field_offset;
        logic [OFS_W-1:0] payload_len;
        logic [63:0]      field_value;
    } result_t;

endpackage

// File: src/pfs_ifs.sv
// ----------------------------------------------------------------------------
// pfs interfaces
// Valid/ready channels for message bytes, scan results and configuration.
// ----------------------------------------------------------------------------
interface pfs_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pfs_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  wire_kind;
    logic [16:0] field_offset;
    logic [16:0] payload_len;
    logic [63:0] field_value;

    modport source (output valid, output status, output wire_kind, output field_offset,
                    output payload_len, output field_value, input ready);
    modport sink   (input valid, input status, input wire_kind, input field_offset,
                    input payload_len, input field_value, output ready);
endinterface

interface pfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_field;

    modport source (output valid, output target_field, input ready);
    modport sink   (input valid, input target_field, output ready);
endinterface

// File: src/protobuf_field_scanner.sv
// The result register loads a result when the scan stage takes the byte that decides it.
// Throughput: one message byte per cycle while the result register can take a result.
// A waiting result stalls the scan stage and, through the input register, the byte channel.
// Reset clears all message state and sets target_field to 1; no clearing pass.
// ----------------------------------------------------------------------------
// protobuf_field_scanner
// Scans a protobuf message byte by byte and reports the field with the target number.
// ----------------------------------------------------------------------------
module protobuf_field_scanner
(
    input  logic         clk,
    input  logic         rst_n,
    pfs_msg_if.sink      msg,
    pfs_result_if.source result,
    pfs_cfg_if.sink      cfg
);

    logic             item_valid;
    pfs_pkg::item_t   item;
    logic             out_free;
    logic             advance;
    logic             res_valid;
    pfs_pkg::result_t res;

    assign advance = item_valid && out_free;

    pfs_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pfs_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .take      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pfs_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take      (advance),
        .free      (out_free),
        .result    (result)
    );

endmodule

// File: src/pfs_in_stage.sv
// ----------------------------------------------------------------------------
// pfs_in_stage
// Input register: holds one message byte until the scan stage takes it.
// ----------------------------------------------------------------------------
module pfs_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    pfs_msg_if.sink        msg,
    input  logic           advance,
    output logic           item_valid,
    output pfs_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    pfs_pkg::item_t item_reg;
    logic           load;

    assign msg.ready  = !valid_reg || advance;
    assign load       = msg.valid && msg.ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte <= msg.data_byte;
            item_reg.last_byte <= msg.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/pfs_step.sv
// ----------------------------------------------------------------------------
// pfs_step
// Per-byte scan: tag and varint decode, payload skipping and field match.
// ----------------------------------------------------------------------------
module pfs_step
(
    input  logic             clk,
    input  logic             rst_n,
    pfs_cfg_if.sink          cfg,
    input  logic             take,
    input  pfs_pkg::item_t   item,
    output logic             res_valid,
    output pfs_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENPFX,
        PH_SKIP
    } phase_t;

    logic [31:0]                target_reg;
    phase_t                     phase_reg, phase_next;
    logic [63:0]                accum_reg, accum_next;
    logic [3:0]                 shift_reg, shift_next;
    logic [2:0]                 wt_reg, wt_next;
    logic                       tgt_reg, tgt_next;
    logic [pfs_pkg::OFS_W-1:0]  offset_reg, offset_next;
    logic [pfs_pkg::OFS_W-1:0]  pstart_reg, pstart_next;
    logic [pfs_pkg::OFS_W-1:0]  remain_reg, remain_next;
    logic                       decided_reg, decided_next;

    logic [6:0]                 amt_full;
    logic [63:0]                acc_new;
    logic [3:0]                 shift_inc;
    logic [pfs_pkg::OFS_W-1:0]  pos_p1;
    logic [pfs_pkg::OFS_W-1:0]  room;
    logic [pfs_pkg::OFS_W-1:0]  flen;
    logic                       over;
    logic                       len_bad;

    assign cfg.ready = 1'b1;

    // Each varint byte lands 7 bits further up; bits past bit 63 drop out.
    assign amt_full  = 7'({shift_reg, 3'b000}) - 7'(shift_reg);
    assign acc_new   = accum_reg | (64'(item.data_byte[6:0]) << amt_full[5:0]);
    assign shift_inc = shift_reg + 4'd1;
    assign pos_p1    = offset_reg + 1'b1;
    assign room      = pfs_pkg::MAX_MSG - pos_p1;
    assign flen      = pos_p1 - pstart_reg;
    assign over      = (offset_reg == pfs_pkg::MAX_MSG);
    assign len_bad   = (|acc_new[63:pfs_pkg::OFS_W]) || (acc_new[pfs_pkg::OFS_W-1:0] > room);

    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        shift_next   = shift_reg;
        wt_next      = wt_reg;
        tgt_next     = tgt_reg;
        offset_next  = offset_reg;
        pstart_next  = pstart_reg;
        remain_next  = remain_reg;
        decided_next = decided_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (take)
        begin
            if (!decided_reg)
            begin
                if (over)
                begin
                    res_valid    = 1'b1;
                    res.status   = pfs_pkg::ST_MALFORMED;
                    decided_next = 1'b1;
                end
                else if (phase_reg == PH_SKIP)
                begin
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == pfs_pkg::OFS_W'(1))
                    begin
                        phase_next = PH_TAG;
                        if (tgt_reg)
                        begin
                            res_valid        = 1'b1;
                            res.status       = pfs_pkg::ST_FOUND;
                            res.wire_kind    = wt_reg;
                            res.field_offset = pstart_reg;
                            res.payload_len  = flen;
                            decided_next     = 1'b1;
                        end
                    end
                end
                else
                begin
                    accum_next = acc_new;
                    shift_next = shift_inc;
                    if (item.data_byte[7])
                    begin
                        if (shift_inc >= pfs_pkg::VARINT_MAX_BYTES)
                        begin
                            res_valid    = 1'b1;
                            res.status   = pfs_pkg::ST_MALFORMED;
                            decided_next = 1'b1;
                        end
                    end
                    else
                    begin
                        accum_next = '0;
                        shift_next = '0;
                        case (phase_reg)
                            PH_TAG:
                            begin
                                wt_next     = acc_new[2:0];
                                tgt_next    = (acc_new[34:3] == target_reg);
                                pstart_next = pos_p1;
                                case (acc_new[2:0])
                                    pfs_pkg::WT_VARINT: phase_next = PH_VALUE;
                                    pfs_pkg::WT_I64:
                                    begin
                                        phase_next  = PH_SKIP;
                                        remain_next = pfs_pkg::OFS_W'(8);
                                    end
                                    pfs_pkg::WT_LEN: phase_next = PH_LENPFX;
                                    pfs_pkg::WT_I32:
                                    begin
                                        phase_next  = PH_SKIP;
                                        remain_next = pfs_pkg::OFS_W'(4);
                                    end
                                    default:
                                    begin
                                        res_valid    = 1'b1;
                                        res.status   = pfs_pkg::ST_MALFORMED;
                                        decided_next = 1'b1;
                                    end
                                endcase
                            end
                            PH_VALUE:
                            begin
                                phase_next = PH_TAG;
                                if (tgt_reg)
                                begin
                                    res_valid        = 1'b1;
                                    res.status       = pfs_pkg::ST_FOUND;
                                    res.wire_kind    = wt_reg;
                                    res.field_offset = pstart_reg;
                                    res.payload_len  = flen;
                                    res.field_value  = acc_new;
                                    decided_next     = 1'b1;
                                end
                            end
                            PH_LENPFX:
                            begin
                                if (len_bad)
                                begin
                                    res_valid    = 1'b1;
                                    res.status   = pfs_pkg::ST_MALFORMED;
                                    decided_next = 1'b1;
                                end
                                else if (acc_new == 64'd0)
                                begin
                                    // An empty string ends with its length prefix.
                                    phase_next = PH_TAG;
                                    if (tgt_reg)
                                    begin
                                        res_valid        = 1'b1;
                                        res.status       = pfs_pkg::ST_FOUND;
                                        res.wire_kind    = wt_reg;
                                        res.field_offset = pstart_reg;
                                        res.payload_len  = flen;
                                        decided_next     = 1'b1;
                                    end
                                end
                                else
                                begin
                                    remain_next = acc_new[pfs_pkg::OFS_W-1:0];
                                    phase_next  = PH_SKIP;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            if (!over)
            begin
                offset_next = pos_p1;
            end

            if (item.last_byte)
            begin
                if (!decided_next)
                begin
                    res_valid  = 1'b1;
                    res        = '0;
                    res.status = (phase_next == PH_TAG && shift_next == 4'd0) ?
                                 pfs_pkg::ST_NOT_FOUND : pfs_pkg::ST_MALFORMED;
                end
                // The next message starts from a clean slate.
                phase_next   = PH_TAG;
                accum_next   = '0;
                shift_next   = '0;
                wt_next      = '0;
                tgt_next     = 1'b0;
                offset_next  = '0;
                pstart_next  = '0;
                remain_next  = '0;
                decided_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= 32'd1;
            phase_reg   <= PH_TAG;
            accum_reg   <= '0;
            shift_reg   <= '0;
            wt_reg      <= '0;
            tgt_reg     <= 1'b0;
            offset_reg  <= '0;
            pstart_reg  <= '0;
            remain_reg  <= '0;
            decided_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                target_reg <= cfg.target_field;
            end
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            shift_reg   <= shift_next;
            wt_reg      <= wt_next;
            tgt_reg     <= tgt_next;
            offset_reg  <= offset_next;
            pstart_reg  <= pstart_next;
            remain_reg  <= remain_next;
            decided_reg <= decided_next;
        end
    end

`ifndef SYNTHESIS
    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !decided_reg |-> shift_reg < pfs_pkg::VARINT_MAX_BYTES)
        else $error("varint byte count out of range while scanning");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> remain_reg != '0)
        else $error("skip phase with nothing left to skip");

    a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= pfs_pkg::MAX_MSG)
        else $error("byte offset ran past its saturation point");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid |-> !decided_reg)
        else $error("second result for one message");

    a_found_shape: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid && res.status == pfs_pkg::ST_FOUND
        |-> res.payload_len != '0 && res.field_offset != '0)
        else $error("found field with empty position");
`endif

endmodule

// File: src/pfs_out_stage.sv
// ----------------------------------------------------------------------------
// pfs_out_stage
// Result register: holds a scan result until the consumer takes it.
// ----------------------------------------------------------------------------
module pfs_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  pfs_pkg::result_t res,
    input  logic             take,
    output logic             free,
    pfs_result_if.source     result
);

    logic             valid_reg;
    logic             valid_next;
    pfs_pkg::result_t res_reg;
    logic             load;

    assign free       = !valid_reg || result.ready;
    assign load       = take && res_valid;
    assign valid_next = load ? 1'b1 : (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.status       = res_reg.status;
    assign result.wire_kind    = res_reg.wire_kind;
    assign result.field_offset = res_reg.field_offset;
    assign result.payload_len  = res_reg.payload_len;
    assign result.field_value  = res_reg.field_value;

endmodule
